// ===== src/xrgc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrgc_pkg
// Shared widths, register codes and types of the XYZ to display RGB unit.
// ----------------------------------------------------------------------------
package xrgc_pkg;

	localparam int CURVE_TOP_DEF = 1500;

	localparam int XYZ_W     = 20;
	localparam int COEF_W    = 20;
	localparam int ROW_W     = 3 * COEF_W;
	localparam int BLACK_W   = 16;
	localparam int SCALE_W   = 20;
	localparam int CODE_W    = 8;
	localparam int CH_W      = 2;
	localparam int IDX_IN_W  = 11;

	localparam int PROD_W    = 2 * XYZ_W;
	localparam int LUM_W     = PROD_W + 2;
	localparam int OFS_W     = PROD_W;
	localparam int BLK_SH    = 16;
	localparam int FRAC_W    = 36;
	localparam int P_W       = OFS_W + SCALE_W - FRAC_W + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USED_W = 3 * CODE_W + 1;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_CONVERT = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATRIX_RED,
		REG_MATRIX_GREEN,
		REG_MATRIX_BLUE,
		REG_BLACK_LEVELS,
		REG_CHANNEL_SCALES,
		REG_WHITE_CODES,
		REG_DISPLAY_MODE
	} cfg_reg_t;

	typedef enum logic [CH_W-1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} chan_t;

	typedef struct packed {
		logic                en;
		logic [IDX_IN_W-1:0] index;
		logic [CODE_W-1:0]   code;
	} curve_wr_t;

endpackage

// ===== src/xyz_to_display_rgb_gamut_clamp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyz_to_display_rgb_gamut_clamp_unit
// XYZ to display RGB: 3x3 matrix, black-level clamp, gamma curve or linear.
// ----------------------------------------------------------------------------
// Takes one item per clock while s_tready is high; a convert item passes
// through the input register, product stage, sum and black clamp, scale
// multiply, curve memory read and output register on its way to m_tvalid. Load
// items take the same path and write the curve memory at the lookup stage,
// so loads and converts act in the order they were accepted. The curve
// memories have no clearing pass and hold garbage until loaded. An output
// skid register keeps s_tready a registered signal; it drops only after two
// results wait at the output.
module xyz_to_display_rgb_gamut_clamp_unit #(
	parameter int CURVE_TOP = xrgc_pkg::CURVE_TOP_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [xrgc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [xrgc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// x_value, y_value, z_value, curve_channel, curve_index, curve_code, zeros
	input  logic [xrgc_pkg::IN_DATA_W-1:0]      s_tdata,
	// action
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// red_code, green_code, blue_code, out_of_gamut, zeros
	output logic [xrgc_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import xrgc_pkg::*;

	localparam int X_LO  = 0;
	localparam int Y_LO  = X_LO + XYZ_W;
	localparam int Z_LO  = Y_LO + XYZ_W;
	localparam int CH_LO = Z_LO + XYZ_W;
	localparam int IX_LO = CH_LO + CH_W;
	localparam int CD_LO = IX_LO + IDX_IN_W;

	logic [ROW_W-1:0]       mrow_r_q, mrow_g_q, mrow_b_q;
	logic [3*BLACK_W-1:0]   black_q;
	logic [3*SCALE_W-1:0]   scale_q;
	logic [3*CODE_W-1:0]    white_q;
	logic                   mode_q;

	logic                   en;
	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                   act_s1, act_s2, act_s3, act_s4, act_s5;
	logic signed [XYZ_W-1:0] x_s1, y_s1, z_s1;
	logic [CH_W-1:0]        ch_s1, ch_s2, ch_s3, ch_s4;
	logic [IDX_IN_W-1:0]    idx_s1, idx_s2, idx_s3, idx_s4;
	logic [CODE_W-1:0]      cc_s1, cc_s2, cc_s3, cc_s4;

	logic [P_W-1:0]         p_r_s4, p_g_s4, p_b_s4;
	logic                   un_r_s4, un_g_s4, un_b_s4;
	logic                   ld_ok;
	curve_wr_t              wr_r, wr_g, wr_b;
	logic [CODE_W-1:0]      code_r, code_g, code_b;
	logic                   fl_r_s5, fl_g_s5, fl_b_s5;

	logic                   push;
	logic [OUT_DATA_W-1:0]  d5;
	logic                   out_vld_q, skid_vld_q;
	logic [OUT_DATA_W-1:0]  out_dat_q, skid_dat_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrow_r_q <= '0;
			mrow_g_q <= '0;
			mrow_b_q <= '0;
			black_q  <= '0;
			scale_q  <= '0;
			white_q  <= '1;
			mode_q   <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MATRIX_RED:     mrow_r_q <= cfg_data[ROW_W-1:0];
				REG_MATRIX_GREEN:   mrow_g_q <= cfg_data[ROW_W-1:0];
				REG_MATRIX_BLUE:    mrow_b_q <= cfg_data[ROW_W-1:0];
				REG_BLACK_LEVELS:   black_q  <= cfg_data[3*BLACK_W-1:0];
				REG_CHANNEL_SCALES: scale_q  <= cfg_data[3*SCALE_W-1:0];
				REG_WHITE_CODES:    white_q  <= cfg_data[3*CODE_W-1:0];
				REG_DISPLAY_MODE:   mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipeline advances whenever the skid register is free
	assign en       = !skid_vld_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= s_tuser;
			x_s1   <= s_tdata[X_LO +: XYZ_W];
			y_s1   <= s_tdata[Y_LO +: XYZ_W];
			z_s1   <= s_tdata[Z_LO +: XYZ_W];
			ch_s1  <= s_tdata[CH_LO +: CH_W];
			idx_s1 <= s_tdata[IX_LO +: IDX_IN_W];
			cc_s1  <= s_tdata[CD_LO +: CODE_W];
			act_s2 <= act_s1;
			act_s3 <= act_s2;
			act_s4 <= act_s3;
			act_s5 <= act_s4;
			ch_s2  <= ch_s1;
			ch_s3  <= ch_s2;
			ch_s4  <= ch_s3;
			idx_s2 <= idx_s1;
			idx_s3 <= idx_s2;
			idx_s4 <= idx_s3;
			cc_s2  <= cc_s1;
			cc_s3  <= cc_s2;
			cc_s4  <= cc_s3;
		end
	end

	xrgc_chan u_chan_r (
		.clk(clk), .en(en), .row(mrow_r_q),
		.black(black_q[0 +: BLACK_W]), .scale(scale_q[0 +: SCALE_W]),
		.x_s1(x_s1), .y_s1(y_s1), .z_s1(z_s1),
		.p_s4(p_r_s4), .under_s4(un_r_s4)
	);

	xrgc_chan u_chan_g (
		.clk(clk), .en(en), .row(mrow_g_q),
		.black(black_q[BLACK_W +: BLACK_W]), .scale(scale_q[SCALE_W +: SCALE_W]),
		.x_s1(x_s1), .y_s1(y_s1), .z_s1(z_s1),
		.p_s4(p_g_s4), .under_s4(un_g_s4)
	);

	xrgc_chan u_chan_b (
		.clk(clk), .en(en), .row(mrow_b_q),
		.black(black_q[2*BLACK_W +: BLACK_W]), .scale(scale_q[2*SCALE_W +: SCALE_W]),
		.x_s1(x_s1), .y_s1(y_s1), .z_s1(z_s1),
		.p_s4(p_b_s4), .under_s4(un_b_s4)
	);

	// curve loads; bad channel or index beyond the top is dropped
	assign ld_ok = vld_s4 && (act_s4 == ACT_LOAD) && (32'(idx_s4) <= 32'(CURVE_TOP));

	always_comb begin
		wr_r.en    = ld_ok && (ch_s4 == CH_RED);
		wr_r.index = idx_s4;
		wr_r.code  = cc_s4;
		wr_g.en    = ld_ok && (ch_s4 == CH_GREEN);
		wr_g.index = idx_s4;
		wr_g.code  = cc_s4;
		wr_b.en    = ld_ok && (ch_s4 == CH_BLUE);
		wr_b.index = idx_s4;
		wr_b.code  = cc_s4;
	end

	xrgc_curve #(.CURVE_TOP(CURVE_TOP)) u_curve_r (
		.clk(clk), .en(en), .mode(mode_q), .white(white_q[0 +: CODE_W]),
		.p_s4(p_r_s4), .under_s4(un_r_s4), .wr(wr_r),
		.code(code_r), .flag_s5(fl_r_s5)
	);

	xrgc_curve #(.CURVE_TOP(CURVE_TOP)) u_curve_g (
		.clk(clk), .en(en), .mode(mode_q), .white(white_q[CODE_W +: CODE_W]),
		.p_s4(p_g_s4), .under_s4(un_g_s4), .wr(wr_g),
		.code(code_g), .flag_s5(fl_g_s5)
	);

	xrgc_curve #(.CURVE_TOP(CURVE_TOP)) u_curve_b (
		.clk(clk), .en(en), .mode(mode_q), .white(white_q[2*CODE_W +: CODE_W]),
		.p_s4(p_b_s4), .under_s4(un_b_s4), .wr(wr_b),
		.code(code_b), .flag_s5(fl_b_s5)
	);

	// output register plus skid
	assign push = en && vld_s5 && (act_s5 == ACT_CONVERT);
	assign d5   = {{(OUT_DATA_W-OUT_USED_W){1'b0}},
		fl_r_s5 | fl_g_s5 | fl_b_s5, code_b, code_g, code_r};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_dat_q <= skid_vld_q ? skid_dat_q : d5;
		end else if (push) begin
			skid_dat_q <= d5;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_dat_q;

endmodule

// ===== src/xrgc_chan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrgc_chan
// One gun: matrix row products, black-level clamp and reciprocal scaling.
// ----------------------------------------------------------------------------
module xrgc_chan (
	input  logic                                clk,
	input  logic                                en,
	input  logic [xrgc_pkg::ROW_W-1:0]          row,
	input  logic [xrgc_pkg::BLACK_W-1:0]        black,
	input  logic [xrgc_pkg::SCALE_W-1:0]        scale,
	input  logic signed [xrgc_pkg::XYZ_W-1:0]   x_s1,
	input  logic signed [xrgc_pkg::XYZ_W-1:0]   y_s1,
	input  logic signed [xrgc_pkg::XYZ_W-1:0]   z_s1,
	output logic [xrgc_pkg::P_W-1:0]            p_s4,
	output logic                                under_s4
);
	import xrgc_pkg::*;

	logic signed [COEF_W-1:0]        cx, cy, cz;
	logic signed [PROD_W-1:0]        px_s2, py_s2, pz_s2;
	logic signed [LUM_W-1:0]         lum, blk, diff;
	logic                            under;
	logic [OFS_W-1:0]                ofs_s3;
	logic                            under_s3;
	logic [OFS_W+SCALE_W-1:0]        prod;

	assign cx = row[COEF_W-1:0];
	assign cy = row[2*COEF_W-1:COEF_W];
	assign cz = row[3*COEF_W-1:2*COEF_W];

	assign lum = {{(LUM_W-PROD_W){px_s2[PROD_W-1]}}, px_s2}
		+ {{(LUM_W-PROD_W){py_s2[PROD_W-1]}}, py_s2}
		+ {{(LUM_W-PROD_W){pz_s2[PROD_W-1]}}, pz_s2};
	assign blk   = {{(LUM_W-BLACK_W-BLK_SH){1'b0}}, black, {BLK_SH{1'b0}}};
	assign under = lum < blk;
	assign diff  = lum - blk;
	assign prod  = ofs_s3 * scale;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2    <= cx * x_s1;
			py_s2    <= cy * y_s1;
			pz_s2    <= cz * z_s1;
			ofs_s3   <= under ? '0 : diff[OFS_W-1:0];
			under_s3 <= under;
			p_s4     <= prod[OFS_W+SCALE_W-1 -: P_W];
			under_s4 <= under_s3;
		end
	end

endmodule

// ===== src/xrgc_curve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrgc_curve
// One gun: gamma curve memory with top clamp, and the linear-mode code path.
// ----------------------------------------------------------------------------
module xrgc_curve #(
	parameter int CURVE_TOP = xrgc_pkg::CURVE_TOP_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          mode,
	input  logic [xrgc_pkg::CODE_W-1:0]   white,
	input  logic [xrgc_pkg::P_W-1:0]      p_s4,
	input  logic                          under_s4,
	input  xrgc_pkg::curve_wr_t           wr,
	output logic [xrgc_pkg::CODE_W-1:0]   code,
	output logic                          flag_s5
);
	import xrgc_pkg::*;

	localparam int IDX_W = $clog2(CURVE_TOP + 1);

	logic [P_W-2:0]      v;
	logic                over;
	logic [IDX_W-1:0]    raddr, waddr;
	logic [P_W:0]        lsum;
	logic [P_W-1:0]      lv;
	logic                lover;
	logic [CODE_W-1:0]   lcode;
	logic                clamp;
	logic [CODE_W-1:0]   mem [0:CURVE_TOP];
	logic [CODE_W-1:0]   rd_s5, lin_s5;

	// curve index: truncated product; linear code: rounded product
	assign v     = p_s4[P_W-1:1];
	assign over  = 32'(v) > 32'(CURVE_TOP);
	assign raddr = over ? IDX_W'(CURVE_TOP) : v[IDX_W-1:0];
	assign waddr = IDX_W'(wr.index);

	assign lsum  = {1'b0, p_s4} + (P_W+1)'(1);
	assign lv    = lsum[P_W:1];
	assign lover = lv > P_W'(white);
	assign lcode = lover ? white : lv[CODE_W-1:0];
	assign clamp = mode ? lover : over;

	always_ff @(posedge clk) begin
		if (en) begin
			if (wr.en) begin
				mem[waddr] <= wr.code;
			end
			rd_s5   <= mem[raddr];
			lin_s5  <= lcode;
			flag_s5 <= under_s4 | clamp;
		end
	end

	assign code = mode ? lin_s5 : rd_s5;

endmodule

// ===== src/xrgc_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrgc_check
// Port-level checks of the XYZ to display RGB unit, bound to the top level.
// ----------------------------------------------------------------------------
module xrgc_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [xrgc_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import xrgc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input back-pressure only while the output holds a result
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("s_tready low with empty output");

	// skid drains only through an output handshake
	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> $past(m_tvalid && m_tready))
		else $error("s_tready rose without output handshake");

	// pad bits above the flag stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_USED_W] == '0)
		else $error("nonzero pad bits in m_tdata");

endmodule

bind xyz_to_display_rgb_gamut_clamp_unit xrgc_check u_xrgc_check (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
